/* sv/bst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and request codes of the bounded sequence table.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_SORTED = 3'd1;
    localparam logic [2:0] REQ_ERASE  = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_GET    = 3'd4;
    localparam logic [2:0] REQ_SET    = 3'd5;
    localparam logic [2:0] REQ_FIND   = 3'd6;

    localparam logic [6:0] CAP_LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  pos;
        logic [31:0] item;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  idx;
        logic [31:0] rd;
        logic [6:0]  removed;
        logic [6:0]  count;
        logic        empty;
    } res_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_t;

endpackage
`default_nettype wire

/* sv/bounded_sequence_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_sequence_table
// Ordered list of up to CAPACITY items with positional and sorted insert,
// erase, remove-all, get, set and find, behind a register port.
//
//   channel  direction  signals
//   s_       in         s_valid s_ready s_req_type s_position s_item_value
//   m_       out        m_valid m_ready m_ok m_result_index m_read_value
//                       m_removed_count m_entry_count m_is_empty
//   apb      in/out     psel penable pwrite paddr pwdata prdata pready
//
// input transfers are spaced by the work of each request, one entry per cycle on
// the single read and write port of the entry store
// the longest gap is a sorted insert at the head of a list one short of full
// s_ready is high only while no request is in flight
// a finished result sits in the output register until its transfer, and a
// second result behind it holds the sequencer and the input
// synchronous active-low reset empties the list and sets the limit to 64
// ----------------------------------------------------------------------------
module bounded_sequence_table #(
    parameter int CAPACITY  = 64,
    parameter int ITEM_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [6:0]  s_position,
    input  wire logic [31:0] s_item_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_ok,
    output logic      [5:0]  m_result_index,
    output logic      [31:0] m_read_value,
    output logic      [6:0]  m_removed_count,
    output logic      [6:0]  m_entry_count,
    output logic             m_is_empty
);

    localparam logic REG_CAP_LIMIT = 1'b0;

    logic [6:0]     cap_limit_reg;
    logic           m_valid_reg;
    bst_pkg::res_t  out_reg;
    bst_pkg::req_t  req;
    bst_pkg::res_t  res;
    logic           seq_idle;
    logic           res_valid;
    logic           res_ready;
    logic           cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAP_LIMIT) ? {25'd0, cap_limit_reg} : 32'd0;

    assign req.kind = s_req_type;
    assign req.pos  = s_position;
    assign req.item = s_item_value;

    assign res_ready = !m_valid_reg || m_ready;

    bst_seq #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid),
        .req       (req),
        .idle      (seq_idle),
        .cap_limit (cap_limit_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_limit_reg <= bst_pkg::CAP_LIMIT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[2] == REG_CAP_LIMIT)) begin
                cap_limit_reg <= pwdata[6:0];
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign s_ready         = seq_idle;
    assign m_valid         = m_valid_reg;
    assign m_ok            = out_reg.ok;
    assign m_result_index  = out_reg.idx;
    assign m_read_value    = out_reg.rd;
    assign m_removed_count = out_reg.removed;
    assign m_entry_count   = out_reg.count;
    assign m_is_empty      = out_reg.empty;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a request is in flight");

    a_removed_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_removed_count != 7'd0)) |-> m_ok)
        else $error("removed count reported on a failed request");

    a_read_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_value != 32'd0)) |-> m_ok)
        else $error("read value reported on a failed request");

    a_index_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_index != 6'd0)) |-> m_ok)
        else $error("index reported on a failed request");
`endif

endmodule
`default_nettype wire

/* sv/bst_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bst_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bst_mem #(
    parameter int  DEPTH,
    parameter int  WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* sv/bst_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bst_cmp
// Shared comparator: read entry against the request item.
// ----------------------------------------------------------------------------
module bst_cmp #(
    parameter int WIDTH
) (
    input  wire logic [WIDTH-1:0] entry,
    input  wire logic [WIDTH-1:0] item,
    output bst_pkg::cmp_t         flags
);

    assign flags.eq = (entry == item);
    assign flags.lt = (entry < item);

endmodule
`default_nettype wire

/* sv/bst_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bst_seq
// Request sequencer: scans, shifts and compacts the entry store one entry
// per cycle through the shared comparator and the single memory port pair.
// ----------------------------------------------------------------------------
module bst_seq #(
    parameter int  CAPACITY,
    parameter int  ITEM_BITS,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire bst_pkg::req_t req,
    output logic               idle,
    input  wire logic [6:0]    cap_limit,
    output logic               res_valid,
    input  wire logic          res_ready,
    output bst_pkg::res_t      res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHUP,
        S_PUT,
        S_SHDN,
        S_GET,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           kind_reg;
    logic [6:0]           pos_reg;
    logic [ITEM_BITS-1:0] item_reg;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     rp_reg, rp_next;
    logic [CNT_W-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]     tgt_reg, tgt_next;
    logic                 pend_reg, pend_next;
    logic                 ok_reg, ok_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [31:0]          rd_reg, rd_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ITEM_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [ITEM_BITS-1:0] mem_rdata;
    bst_pkg::cmp_t        cmp;

    logic [CMP_W-1:0]     lim_w;
    logic [CMP_W-1:0]     fill_w;
    logic [CMP_W-1:0]     pos_w;
    logic                 has_room;
    logic [CNT_W-1:0]     rp_dec;

    bst_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ITEM_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    bst_cmp #(
        .WIDTH (ITEM_BITS)
    ) u_cmp (
        .entry (mem_rdata),
        .item  (item_reg),
        .flags (cmp)
    );

    assign lim_w    = (CMP_W'(cap_limit) < CMP_W'(CAPACITY)) ? CMP_W'(cap_limit)
                                                             : CMP_W'(CAPACITY);
    assign fill_w   = CMP_W'(fill_reg);
    assign pos_w    = CMP_W'(pos_reg);
    assign has_room = (fill_w < lim_w);
    assign rp_dec   = rp_reg - CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        tgt_next   = tgt_reg;
        pend_next  = 1'b0;
        ok_next    = ok_reg;
        idx_next   = idx_reg;
        rd_next    = rd_reg;
        rem_next   = rem_reg;
        mem_we     = 1'b0;
        mem_waddr  = wp_reg[IDX_W-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = rp_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                ok_next    = 1'b0;
                idx_next   = '0;
                rd_next    = '0;
                rem_next   = '0;
                state_next = S_DONE;
                case (kind_reg)
                    bst_pkg::REQ_INSERT: begin
                        if (has_room && (pos_w <= fill_w)) begin
                            tgt_next   = CNT_W'(pos_reg);
                            rp_next    = fill_reg;
                            state_next = S_SHUP;
                        end
                    end
                    bst_pkg::REQ_SORTED: begin
                        if (has_room) begin
                            rp_next    = '0;
                            state_next = S_SCAN;
                        end
                    end
                    bst_pkg::REQ_ERASE: begin
                        if (pos_w < fill_w) begin
                            rp_next    = CNT_W'(pos_reg) + CNT_W'(1);
                            state_next = S_SHDN;
                        end
                    end
                    bst_pkg::REQ_REMOVE: begin
                        rp_next    = '0;
                        wp_next    = '0;
                        state_next = S_SCAN;
                    end
                    bst_pkg::REQ_GET: begin
                        if (pos_w < fill_w) begin
                            mem_raddr  = IDX_W'(pos_reg);
                            state_next = S_GET;
                        end
                    end
                    bst_pkg::REQ_SET: begin
                        if (pos_w < fill_w) begin
                            mem_we    = 1'b1;
                            mem_waddr = IDX_W'(pos_reg);
                            mem_wdata = item_reg;
                            ok_next   = 1'b1;
                        end
                    end
                    bst_pkg::REQ_FIND: begin
                        rp_next    = '0;
                        state_next = S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (rp_reg < fill_reg) begin
                    pend_next = 1'b1;
                    rp_next   = rp_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    case (kind_reg)
                        bst_pkg::REQ_SORTED: begin
                            if (!cmp.lt) begin
                                tgt_next   = rp_dec;
                                rp_next    = fill_reg;
                                pend_next  = 1'b0;
                                state_next = S_SHUP;
                            end
                        end
                        bst_pkg::REQ_FIND: begin
                            if (cmp.eq) begin
                                ok_next    = 1'b1;
                                idx_next   = rp_dec;
                                pend_next  = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        bst_pkg::REQ_REMOVE: begin
                            if (!cmp.eq) begin
                                mem_we    = 1'b1;
                                mem_waddr = wp_reg[IDX_W-1:0];
                                mem_wdata = mem_rdata;
                                wp_next   = wp_reg + CNT_W'(1);
                            end else begin
                                rem_next = rem_reg + CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (rp_reg >= fill_reg) begin
                    case (kind_reg)
                        bst_pkg::REQ_SORTED: begin
                            tgt_next   = fill_reg;
                            rp_next    = fill_reg;
                            state_next = S_SHUP;
                        end
                        bst_pkg::REQ_REMOVE: begin
                            fill_next  = wp_reg;
                            ok_next    = (rem_reg != '0);
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SHUP: begin
                mem_raddr = rp_dec[IDX_W-1:0];
                if (rp_reg > tgt_reg) begin
                    pend_next = 1'b1;
                    wp_next   = rp_reg;
                    rp_next   = rp_dec;
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wp_reg[IDX_W-1:0];
                    mem_wdata = mem_rdata;
                end else if (rp_reg <= tgt_reg) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = tgt_reg[IDX_W-1:0];
                mem_wdata  = item_reg;
                fill_next  = fill_reg + CNT_W'(1);
                ok_next    = 1'b1;
                idx_next   = tgt_reg;
                state_next = S_DONE;
            end
            S_SHDN: begin
                if (rp_reg < fill_reg) begin
                    pend_next = 1'b1;
                    wp_next   = rp_dec;
                    rp_next   = rp_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wp_reg[IDX_W-1:0];
                    mem_wdata = mem_rdata;
                end else if (rp_reg >= fill_reg) begin
                    fill_next  = fill_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_GET: begin
                rd_next    = 32'(mem_rdata);
                ok_next    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
            ok_reg    <= ok_next;
        end
        rp_reg  <= rp_next;
        wp_reg  <= wp_next;
        tgt_reg <= tgt_next;
        idx_reg <= idx_next;
        rd_reg  <= rd_next;
        rem_reg <= rem_next;
        if (state_reg == S_IDLE) begin
            kind_reg <= req.kind;
            pos_reg  <= req.pos;
            item_reg <= ITEM_BITS'(req.item);
        end
    end

    assign idle        = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.ok      = ok_reg;
    assign res.idx     = 6'(idx_reg);
    assign res.rd      = rd_reg;
    assign res.removed = 7'(rem_reg);
    assign res.count   = 7'(fill_reg);
    assign res.empty   = (fill_reg == '0);

endmodule
`default_nettype wire

/* tb/sv/table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_checker
// Watches the register port and both channels of the bounded sequence table.
// Keeps its own copy of the list, the fill count and the capacity limit,
// works out the result of every accepted request and compares each result
// transfer, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module table_checker #(
    parameter int         CAPACITY   = 64,
    parameter logic [2:0] LIMIT_ADDR = '0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [6:0]  s_position,
    input  logic [31:0] s_item_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_ok,
    input  logic [5:0]  m_result_index,
    input  logic [31:0] m_read_value,
    input  logic [6:0]  m_removed_count,
    input  logic [6:0]  m_entry_count,
    input  logic        m_is_empty,
    output int          error_count,
    output int          pending_results,
    output int          fill_level
);
    import bst_pkg::*;

    logic [31:0] list_copy [CAPACITY];
    int          fill;
    logic [6:0]  cap_limit;
    res_t        expected_results [$];
    res_t        oldest;

    function automatic res_t apply_request(input logic [2:0]  kind,
                                           input logic [6:0]  pos,
                                           input logic [31:0] item);
        res_t outcome;
        int   room;
        int   i;
        int   j;
        outcome = '0;
        room = (int'(cap_limit) < CAPACITY) ? int'(cap_limit) : CAPACITY;
        case (kind)
            REQ_INSERT: begin
                if (fill < room && int'(pos) <= fill) begin
                    for (i = fill; i > int'(pos); i--) list_copy[i] = list_copy[i - 1];
                    list_copy[pos] = item;
                    fill++;
                    outcome.ok  = 1'b1;
                    outcome.idx = pos[5:0];
                end
            end
            REQ_SORTED: begin
                if (fill < room) begin
                    j = 0;
                    while (j < fill && list_copy[j] < item) j++;
                    for (i = fill; i > j; i--) list_copy[i] = list_copy[i - 1];
                    list_copy[j] = item;
                    fill++;
                    outcome.ok  = 1'b1;
                    outcome.idx = j[5:0];
                end
            end
            REQ_ERASE: begin
                if (int'(pos) < fill) begin
                    for (i = int'(pos); i + 1 < fill; i++) list_copy[i] = list_copy[i + 1];
                    fill--;
                    outcome.ok = 1'b1;
                end
            end
            REQ_REMOVE: begin
                j = 0;
                for (i = 0; i < fill; i++) begin
                    if (list_copy[i] != item) begin
                        list_copy[j] = list_copy[i];
                        j++;
                    end else begin
                        outcome.removed = outcome.removed + 7'd1;
                    end
                end
                fill = j;
                outcome.ok = (outcome.removed != '0);
            end
            REQ_GET: begin
                if (int'(pos) < fill) begin
                    outcome.rd = list_copy[pos];
                    outcome.ok = 1'b1;
                end
            end
            REQ_SET: begin
                if (int'(pos) < fill) begin
                    list_copy[pos] = item;
                    outcome.ok = 1'b1;
                end
            end
            REQ_FIND: begin
                for (i = 0; i < fill; i++) begin
                    if (list_copy[i] == item) begin
                        outcome.ok  = 1'b1;
                        outcome.idx = i[5:0];
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        outcome.count = 7'(fill);
        outcome.empty = (fill == 0);
        return outcome;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill      = 0;
            cap_limit = CAP_LIMIT_RESET;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    error_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("ok", 32'(oldest.ok), 32'(m_ok));
                    check_field("result_index", 32'(oldest.idx), 32'(m_result_index));
                    check_field("read_value", oldest.rd, m_read_value);
                    check_field("removed_count", 32'(oldest.removed), 32'(m_removed_count));
                    check_field("entry_count", 32'(oldest.count), 32'(m_entry_count));
                    check_field("is_empty", 32'(oldest.empty), 32'(m_is_empty));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_request(s_req_type, s_position,
                                                         s_item_value));
            end
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
                cap_limit = pwdata[6:0];
            end
        end
        pending_results = expected_results.size();
        fill_level      = fill;
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds request streams and capacity limit writes into the bounded sequence
// table with bursty input, a stalling result side and long back-pressure
// stretches. The table_checker alongside predicts and compares every result;
// this module only generates traffic and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import bst_pkg::*;

    localparam int         CLK_PERIOD    = 8;
    localparam int         CAPACITY      = 64;
    localparam logic [2:0] REG_CAP_LIMIT = 3'd0;
    localparam logic [2:0] REQ_UNUSED    = 3'd7;
    localparam int         PHASE_ITEMS   = 165;
    localparam int         DRAIN_CYCLES  = 2 * CAPACITY + 10;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type   = REQ_GET;
    logic [6:0]  s_position   = '0;
    logic [31:0] s_item_value = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_ok;
    logic [5:0]  m_result_index;
    logic [31:0] m_read_value;
    logic [6:0]  m_removed_count;
    logic [6:0]  m_entry_count;
    logic        m_is_empty;
    int          error_count;
    int          pending_results;
    int          fill_level;

    bounded_sequence_table DUT (.*);

    table_checker #(
        .CAPACITY   (CAPACITY),
        .LIMIT_ADDR (REG_CAP_LIMIT)
    ) result_check (.*);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic drive_request(input logic [2:0] kind, input logic [6:0] pos,
                                 input logic [31:0] item);
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_position   <= pos;
        s_item_value <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic issue(input logic [2:0] kind, input logic [6:0] pos,
                         input logic [31:0] item);
        @(negedge aclk);
        drive_request(kind, pos, item);
    endtask

    task automatic pause_sender(input int gap);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (gap) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [6:0] value);
        while (pending_results != 0) @(negedge aclk);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAP_LIMIT;
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input bit grow);
        int          sent;
        int          burst;
        int          pick;
        logic [2:0]  kind;
        logic [6:0]  pos;
        logic [31:0] item;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            repeat (burst) begin
                @(negedge aclk);
                pick = $urandom_range(0, 99);
                if (grow) begin
                    kind = (pick < 25) ? REQ_INSERT : (pick < 60) ? REQ_SORTED :
                           (pick < 67) ? REQ_ERASE  : (pick < 72) ? REQ_REMOVE :
                           (pick < 82) ? REQ_GET    : (pick < 89) ? REQ_SET    :
                           (pick < 97) ? REQ_FIND   : REQ_UNUSED;
                end else begin
                    kind = (pick < 10) ? REQ_INSERT : (pick < 22) ? REQ_SORTED :
                           (pick < 52) ? REQ_ERASE  : (pick < 64) ? REQ_REMOVE :
                           (pick < 76) ? REQ_GET    : (pick < 84) ? REQ_SET    :
                           (pick < 97) ? REQ_FIND   : REQ_UNUSED;
                end
                // a small set of repeated values so that remove and find hit
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            item = 32'h0000_0000;
                        end
                        1: begin
                            item = 32'hFFFF_FFFF;
                        end
                        2: begin
                            item = 32'h8000_0000;
                        end
                        3: begin
                            item = 32'h7FFF_FFFF;
                        end
                        default: begin
                            item = $urandom_range(1, 6);
                        end
                    endcase
                end else if (pick < 90) begin
                    item = $urandom();
                end else begin
                    item = $urandom_range(0, 15);
                end
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    pos = 7'($urandom_range(0, fill_level + 1));
                end else if (pick < 90) begin
                    pos = 7'(fill_level);
                end else begin
                    pos = 7'($urandom_range(0, 127));
                end
                drive_request(kind, pos, item);
                if (kind != REQ_UNUSED) sent++;
            end
            pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 5));
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_limit(CAP_LIMIT_RESET);

        // empty list, edge positions and values, duplicates, every request kind
        issue(REQ_GET, 7'd0, 32'h0);
        issue(REQ_ERASE, 7'd0, 32'h0);
        issue(REQ_REMOVE, 7'd0, 32'h0);
        issue(REQ_FIND, 7'd0, 32'h0);
        issue(REQ_SET, 7'd0, 32'hFFFF_FFFF);
        issue(REQ_INSERT, 7'd1, 32'h5);
        issue(REQ_INSERT, 7'd0, 32'h0000_0000);
        issue(REQ_INSERT, 7'd1, 32'hFFFF_FFFF);
        issue(REQ_SORTED, 7'd0, 32'h8000_0000);
        issue(REQ_SORTED, 7'd0, 32'h0000_0000);
        issue(REQ_SORTED, 7'd0, 32'hFFFF_FFFF);
        issue(REQ_FIND, 7'd0, 32'hFFFF_FFFF);
        issue(REQ_FIND, 7'd0, 32'h1234_5678);
        issue(REQ_GET, 7'd127, 32'h0);
        issue(REQ_GET, 7'd4, 32'h0);
        issue(REQ_SET, 7'd2, 32'h5555_5555);
        issue(REQ_SET, 7'd5, 32'h1);
        issue(REQ_INSERT, 7'd127, 32'h1);
        issue(REQ_INSERT, 7'd5, 32'hAAAA_AAAA);
        issue(REQ_ERASE, 7'd6, 32'h0);
        issue(REQ_ERASE, 7'd0, 32'h0);
        issue(REQ_REMOVE, 7'd0, 32'hFFFF_FFFF);
        issue(REQ_REMOVE, 7'd0, 32'h1234_5678);
        issue(REQ_UNUSED, 7'd64, 32'h1);
        issue(REQ_GET, 7'd0, 32'h0);
        pause_sender(2);

        write_limit(CAP_LIMIT_RESET);
        run_phase(1'b1);
        write_limit(7'd5);
        run_phase(1'b0);
        write_limit(7'd0);
        run_phase(1'b1);
        write_limit(7'd1);
        run_phase(1'b1);
        write_limit(7'd127);
        run_phase(1'b1);
        write_limit(7'd2);
        run_phase(1'b0);
        write_limit(7'($urandom_range(1, CAPACITY)));
        run_phase(1'b1);
        write_limit(CAP_LIMIT_RESET);
        run_phase(1'b0);

        while (pending_results != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : result_sink
        int sink_cycles;
        int next_long_hold;
        int mode;
        int stretch;
        int k;
        sink_cycles    = 0;
        next_long_hold = 3000;
        forever begin
            if (sink_cycles >= next_long_hold) begin
                // long hold-off so that requests back up behind the held result
                repeat (300) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                    sink_cycles++;
                end
                next_long_hold = sink_cycles + $urandom_range(15000, 25000);
            end
            mode    = $urandom_range(0, 9);
            stretch = $urandom_range(4, 60);
            for (k = 0; k < stretch; k++) begin
                @(negedge aclk);
                if (mode < 4) begin
                    m_ready <= 1'b1;
                end else if (mode < 7) begin
                    m_ready <= 1'($urandom_range(0, 1));
                end else if (mode < 9) begin
                    m_ready <= (k % 4 == 0);
                end else begin
                    m_ready <= 1'b0;
                end
                sink_cycles++;
            end
        end
    end

    initial begin : watchdog
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
sv/bst_pkg.sv
sv/bst_mem.sv
sv/bst_cmp.sv
sv/bst_seq.sv
sv/bounded_sequence_table.sv
tb/sv/table_checker.sv
tb/sv/testbench.sv
